FILE: design/hufd_pkg.sv
// ---------------------------------------------------------------------------
// hufd_pkg
// Types and constants shared by the Huffman node-table decoder modules.
// ---------------------------------------------------------------------------
package hufd_pkg;

    localparam int NODE_COUNT_W = 13;
    localparam int ROOT_W       = 12;
    localparam int CAP_W        = 16;
    localparam int LEN_W        = 16;
    localparam int WALK_W       = 16;
    localparam int BOUND_W      = 17;
    localparam int WORD_W       = 32;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int BIT_CNT_W    = 4;

    localparam logic [15:0]             LEAF_TAG       = 16'hFFFF;
    localparam logic [BIT_CNT_W-1:0]    BITS_PER_BYTE  = 4'd8;
    localparam logic [NODE_COUNT_W-1:0] RST_NODE_COUNT = 13'd1;
    localparam logic [ROOT_W-1:0]       RST_ROOT_INDEX = 12'd0;
    localparam logic [CAP_W-1:0]        RST_OUT_CAP    = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_WRITE_NODE = 2'd0,
        CMD_START      = 2'd1,
        CMD_DATA       = 2'd2,
        CMD_END        = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        STAT_RUNNING    = 3'd0,
        STAT_OK         = 3'd1,
        STAT_NO_TERM    = 3'd2,
        STAT_TRUNCATED  = 3'd3,
        STAT_BAD_NODE   = 3'd4,
        STAT_BAD_SYMBOL = 3'd5,
        STAT_OVERFLOW   = 3'd6,
        STAT_BAD_ROOT   = 3'd7
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NODE_COUNT   = 2'd0,
        CFG_ROOT_INDEX   = 2'd1,
        CFG_OUT_CAPACITY = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_CHK,
        ST_ROOT_CHK,
        ST_FETCH,
        ST_STEP,
        ST_CLOSE,
        ST_END
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] node_index;
        logic [31:0] node_word;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic        has_symbol;
        logic [7:0]  symbol_low;
        logic [7:0]  symbol_high;
        logic [2:0]  status;
        logic [15:0] decoded_length;
        logic        last_of_run;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic    wr_node;
        logic    start_init;
        logic    cap_byte;
        logic    rd_root;
        logic    rd_walk;
        logic    set_active;
        logic    take_child;
        logic    sym_take;
        logic    clr_active;
        logic    emit;
        logic    emit_has;
        status_t emit_status;
        logic    emit_last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic active;
        logic start_bad;
        logic word_leaf;
        logic walk_oob;
        logic child_oob;
        logic moved;
        logic bit_done;
        logic bad_sym;
        logic overflow;
        logic terminator;
        logic walk_at_root;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/hufd_dp.sv
// ---------------------------------------------------------------------------
// hufd_dp
// Datapath: node table memory, walk and length registers, configuration
// registers and the result output register.
// ---------------------------------------------------------------------------
module hufd_dp import hufd_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_item_t              s_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  m_ready,
    output logic                  m_valid,
    output out_item_t             m_data,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [BOUND_W-1:0] DEPTH_L = BOUND_W'(TABLE_DEPTH);

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [NODE_COUNT_W-1:0] node_count_reg, node_count_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [CAP_W-1:0]        cap_reg, cap_next;
    logic [WALK_W-1:0]       walk_reg, walk_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    active_reg, active_next;
    logic                    moved_reg, moved_next;
    logic [BIT_CNT_W-1:0]    bit_reg, bit_next;
    logic [7:0]              byte_reg;
    logic [WORD_W-1:0]       rdata_reg;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic [BOUND_W-1:0] count_ext, root_ext, walk_ext, child_ext, idx_ext, bound;
    logic [WALK_W-1:0]  child;
    logic [LEN_W:0]     len_sum;
    logic [1:0]         need;
    logic [7:0]         sym_lo, sym_hi;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    assign count_ext = BOUND_W'(node_count_reg);
    assign root_ext  = BOUND_W'(root_reg);
    assign walk_ext  = BOUND_W'(walk_reg);
    assign idx_ext   = BOUND_W'(s_data.node_index);
    assign bound     = (count_ext < DEPTH_L) ? count_ext : DEPTH_L;

    // bit order is lsb first
    assign child     = byte_reg[bit_reg[2:0]] ? rdata_reg[31:16] : rdata_reg[15:0];
    assign child_ext = BOUND_W'(child);

    assign sym_lo  = rdata_reg[7:0];
    assign sym_hi  = rdata_reg[15:8];
    assign need    = (sym_hi != 8'd0) ? 2'd2 : 2'd1;
    assign len_sum = (LEN_W+1)'(len_reg) + (LEN_W+1)'(need);

    // node table
    assign rd_en   = cmd.rd_root | cmd.rd_walk | cmd.take_child;
    assign rd_addr = cmd.rd_root ? root_ext[AW-1:0] :
                     cmd.rd_walk ? walk_ext[AW-1:0] : child_ext[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_node && (idx_ext < DEPTH_L)) begin
            mem[idx_ext[AW-1:0]] <= s_data.node_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        node_count_next = node_count_reg;
        root_next       = root_reg;
        cap_next        = cap_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_NODE_COUNT:   node_count_next = cfg_wdata[NODE_COUNT_W-1:0];
                CFG_ROOT_INDEX:   root_next       = cfg_wdata[ROOT_W-1:0];
                CFG_OUT_CAPACITY: cap_next        = cfg_wdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        walk_next   = walk_reg;
        len_next    = len_reg;
        active_next = active_reg;
        moved_next  = moved_reg;
        bit_next    = bit_reg;
        if (cmd.start_init) begin
            len_next    = '0;
            active_next = 1'b0;
        end
        if (cmd.cap_byte) begin
            bit_next   = '0;
            moved_next = 1'b0;
        end
        if (cmd.set_active) begin
            active_next = 1'b1;
            walk_next   = WALK_W'(root_reg);
        end
        if (cmd.take_child) begin
            walk_next  = child;
            moved_next = 1'b1;
            bit_next   = bit_reg + 1'b1;
        end
        if (cmd.sym_take) begin
            len_next   = len_sum[LEN_W-1:0];
            walk_next  = WALK_W'(root_reg);
            moved_next = 1'b0;
        end
        if (cmd.clr_active) begin
            active_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next               = 1'b1;
            m_data_next.has_symbol     = cmd.emit_has;
            m_data_next.symbol_low     = cmd.emit_has ? sym_lo : 8'd0;
            m_data_next.symbol_high    = cmd.emit_has ? sym_hi : 8'd0;
            m_data_next.status         = cmd.emit_status;
            m_data_next.decoded_length = cmd.emit_has ? len_sum[LEN_W-1:0] : len_reg;
            m_data_next.last_of_run    = cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= RST_NODE_COUNT;
            root_reg       <= RST_ROOT_INDEX;
            cap_reg        <= RST_OUT_CAP;
            walk_reg       <= '0;
            len_reg        <= '0;
            active_reg     <= 1'b0;
            moved_reg      <= 1'b0;
            bit_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            node_count_reg <= node_count_next;
            root_reg       <= root_next;
            cap_reg        <= cap_next;
            walk_reg       <= walk_next;
            len_reg        <= len_next;
            active_reg     <= active_next;
            moved_reg      <= moved_next;
            bit_reg        <= bit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (cmd.cap_byte) begin
            byte_reg <= s_data.data_byte;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.active       = active_reg;
        stat.start_bad    = (node_count_reg == '0) || (count_ext > DEPTH_L) ||
                            (root_ext >= count_ext);
        stat.word_leaf    = (rdata_reg[31:16] == LEAF_TAG);
        stat.walk_oob     = (walk_ext >= bound);
        stat.child_oob    = (child_ext >= bound);
        stat.moved        = moved_reg;
        stat.bit_done     = (bit_reg == BITS_PER_BYTE);
        stat.bad_sym      = (sym_hi != 8'd0) && (sym_lo == 8'd0);
        stat.overflow     = (len_sum > (LEN_W+1)'(cap_reg));
        stat.terminator   = (sym_hi == 8'd0) && (sym_lo == 8'd0);
        stat.walk_at_root = (walk_reg == WALK_W'(root_reg));
        stat.out_free     = !m_valid_reg || m_ready;
    end

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result written over a beat not yet taken");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= BITS_PER_BYTE)
        else $error("bit counter ran past the byte");

    a_ok_ends_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.emit_status == STAT_OK)) |=> !active_reg)
        else $error("message still active after terminator");

endmodule

FILE: design/hufd_ctrl.sv
// ---------------------------------------------------------------------------
// hufd_ctrl
// Controller: sequences item decode, the per-bit tree walk and result beats.
// ---------------------------------------------------------------------------
module hufd_ctrl import hufd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_command,
    output logic       s_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_START: state_next = ST_START_CHK;
                        CMD_DATA:  state_next = stat.active ? ST_FETCH : ST_IDLE;
                        CMD_END:   state_next = stat.active ? ST_END : ST_IDLE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START_CHK: begin
                if (!stat.start_bad) begin
                    state_next = ST_ROOT_CHK;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT_CHK: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (!stat.walk_oob) begin
                    state_next = ST_STEP;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP: begin
                if (stat.moved && stat.word_leaf) begin
                    if (stat.out_free) begin
                        if (stat.bad_sym || stat.overflow || stat.terminator) begin
                            state_next = ST_IDLE;
                        end else if (stat.bit_done) begin
                            state_next = ST_CLOSE;
                        end else begin
                            state_next = ST_FETCH;
                        end
                    end
                end else if (stat.bit_done || stat.word_leaf || stat.child_oob) begin
                    if (stat.out_free) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLOSE, ST_END: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_command)
                        CMD_WRITE_NODE: cmd.wr_node    = 1'b1;
                        CMD_START:      cmd.start_init = 1'b1;
                        CMD_DATA:       cmd.cap_byte   = stat.active;
                        default: ;
                    endcase
                end
            end
            ST_START_CHK: begin
                if (!stat.start_bad) begin
                    cmd.rd_root = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_BAD_ROOT;
                    cmd.emit_last   = 1'b1;
                end
            end
            ST_ROOT_CHK: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = stat.word_leaf ? STAT_BAD_ROOT : STAT_RUNNING;
                    cmd.set_active  = !stat.word_leaf;
                end
            end
            ST_FETCH: begin
                if (!stat.walk_oob) begin
                    cmd.rd_walk = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_BAD_NODE;
                    cmd.emit_last   = 1'b1;
                    cmd.clr_active  = 1'b1;
                end
            end
            ST_STEP: begin
                if (stat.moved && stat.word_leaf) begin
                    // arrived at a leaf: symbol or error beat
                    if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        if (stat.bad_sym) begin
                            cmd.emit_status = STAT_BAD_SYMBOL;
                            cmd.emit_last   = 1'b1;
                            cmd.clr_active  = 1'b1;
                        end else if (stat.overflow) begin
                            cmd.emit_status = STAT_OVERFLOW;
                            cmd.emit_last   = 1'b1;
                            cmd.clr_active  = 1'b1;
                        end else if (stat.terminator) begin
                            cmd.emit_has    = 1'b1;
                            cmd.emit_status = STAT_OK;
                            cmd.emit_last   = 1'b1;
                            cmd.sym_take    = 1'b1;
                            cmd.clr_active  = 1'b1;
                        end else begin
                            cmd.emit_has    = 1'b1;
                            cmd.emit_status = STAT_RUNNING;
                            cmd.sym_take    = 1'b1;
                        end
                    end
                end else if (stat.bit_done) begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_RUNNING;
                        cmd.emit_last   = 1'b1;
                    end
                end else if (stat.word_leaf || stat.child_oob) begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_BAD_NODE;
                        cmd.emit_last   = 1'b1;
                        cmd.clr_active  = 1'b1;
                    end
                end else begin
                    cmd.take_child = 1'b1;
                end
            end
            ST_CLOSE: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_RUNNING;
                    cmd.emit_last   = 1'b1;
                end
            end
            ST_END: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = stat.walk_at_root ? STAT_NO_TERM : STAT_TRUNCATED;
                    cmd.emit_last   = 1'b1;
                    cmd.clr_active  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    a_step_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && !stat.moved) |-> !stat.bit_done)
        else $error("byte finished without a move into the last node");

    a_close_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLOSE) |-> stat.active)
        else $error("closing beat for an inactive message");

    a_take_after_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_child |-> ($past(state_reg) == ST_FETCH || $past(cmd.take_child)))
        else $error("child step without a fresh node word");

endmodule

FILE: design/huffman_table_bit_decoder_top.sv
// ---------------------------------------------------------------------------
// huffman_table_bit_decoder_top
// Decodes a Huffman bitstream by walking a node table bit by bit.
// ---------------------------------------------------------------------------
// channel   dir   handshake           payload
// s_        in    s_valid/s_ready     in_item_t  (command, node, byte)
// m_        out   m_valid/m_ready     out_item_t (symbol, status, length)
// cfg_      in    cfg_wr_en           cfg_addr, cfg_wdata
//
// a data byte takes one table read per bit on the single read port, each depending on the last
// one item in flight; s_ready is low until its last result is in m_ register
// a stalled m_ready holds the walk; reset is synchronous, table is not cleared
// ---------------------------------------------------------------------------
module huffman_table_bit_decoder_top import hufd_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    hufd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hufd_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: tb/sv/hufd_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// hufd_scoreboard_pkg
// Scoreboard for the Huffman node-table decoder: keeps its own copy of the
// node table, walk state and registers, predicts every result beat and
// compares the beats seen on the result channel in order.
// ---------------------------------------------------------------------------
package hufd_scoreboard_pkg;
    import hufd_pkg::*;

    localparam int TABLE_ENTRIES = 4096;

    class hufd_scoreboard;
        logic [31:0] node_mem [TABLE_ENTRIES];
        bit          node_set [TABLE_ENTRIES];
        logic [11:0] walk_idx;
        logic [15:0] out_len;
        bit          active;
        logic [12:0] node_count;
        logic [11:0] root_idx;
        logic [15:0] out_cap;
        out_item_t   decode_q [$];
        int          errors;
        int          live_beats;

        function new();
            walk_idx   = '0;
            out_len    = '0;
            active     = 1'b0;
            node_count = RST_NODE_COUNT;
            root_idx   = RST_ROOT_INDEX;
            out_cap    = RST_OUT_CAP;
            errors     = 0;
            live_beats = 0;
        endfunction

        function void set_reg(cfg_reg_t a, logic [15:0] v);
            case (a)
                CFG_NODE_COUNT:   node_count = v[12:0];
                CFG_ROOT_INDEX:   root_idx   = v[11:0];
                CFG_OUT_CAPACITY: out_cap    = v;
                default: ;
            endcase
        endfunction

        function bit leaf_word(logic [31:0] w);
            return w[31:16] == LEAF_TAG;
        endfunction

        function out_item_t mk_result(bit has, logic [7:0] lo, logic [7:0] hi, status_t st,
                                      int len);
            out_item_t r;
            r.has_symbol     = has;
            r.symbol_low     = lo;
            r.symbol_high    = hi;
            r.status         = st;
            r.decoded_length = len[15:0];
            r.last_of_run    = 1'b0;
            return r;
        endfunction

        // returns 0 when the beat would read a table entry never written;
        // with commit set, the state advances and the results are queued
        function bit predict_decode(in_item_t it, bit commit);
            out_item_t   res [$];
            out_item_t   r;
            int          bound, walk, len, child, need;
            bit          busy, stop, ended, reads_ok;
            logic [31:0] w;
            logic [15:0] sym;
            status_t     err;
            bound    = (node_count < TABLE_ENTRIES) ? int'(node_count) : TABLE_ENTRIES;
            walk     = int'(walk_idx);
            len      = int'(out_len);
            busy     = active;
            stop     = 1'b0;
            ended    = 1'b0;
            reads_ok = 1'b1;
            err      = STAT_RUNNING;
            case (it.command)
                CMD_WRITE_NODE: begin
                    if (commit) begin
                        node_mem[it.node_index] = it.node_word;
                        node_set[it.node_index] = 1'b1;
                    end
                end
                CMD_START: begin
                    len  = 0;
                    busy = 1'b0;
                    if (node_count == 0 || node_count > TABLE_ENTRIES ||
                        root_idx >= node_count) begin
                        res.push_back(mk_result(1'b0, 8'h00, 8'h00, STAT_BAD_ROOT, len));
                    end else begin
                        reads_ok = node_set[root_idx];
                        if (leaf_word(node_mem[root_idx])) begin
                            res.push_back(mk_result(1'b0, 8'h00, 8'h00, STAT_BAD_ROOT,
                                                    len));
                        end else begin
                            busy = 1'b1;
                            walk = int'(root_idx);
                            res.push_back(mk_result(1'b0, 8'h00, 8'h00, STAT_RUNNING,
                                                    len));
                        end
                    end
                end
                CMD_DATA: begin
                    if (busy) begin
                        for (int b = 0; b < 8 && !stop; b++) begin
                            if (walk >= bound) begin
                                err  = STAT_BAD_NODE;
                                stop = 1'b1;
                            end else begin
                                reads_ok &= node_set[walk];
                                w     = node_mem[walk];
                                child = it.data_byte[b] ? int'(w[31:16]) : int'(w[15:0]);
                                if (leaf_word(w) || child >= bound) begin
                                    err  = STAT_BAD_NODE;
                                    stop = 1'b1;
                                end else begin
                                    walk = child;
                                    reads_ok &= node_set[walk];
                                    w    = node_mem[walk];
                                    sym  = w[15:0];
                                    need = (sym[15:8] != 0) ? 2 : 1;
                                    if (leaf_word(w)) begin
                                        if (sym[15:8] != 0 && sym[7:0] == 0) begin
                                            err  = STAT_BAD_SYMBOL;
                                            stop = 1'b1;
                                        end else if (len + need > out_cap) begin
                                            // nothing of the symbol is counted
                                            err  = STAT_OVERFLOW;
                                            stop = 1'b1;
                                        end else begin
                                            len += need;
                                            if (sym == 0) begin
                                                res.push_back(mk_result(1'b1, 8'h00, 8'h00,
                                                                        STAT_OK, len));
                                                ended = 1'b1;
                                                stop  = 1'b1;
                                            end else begin
                                                res.push_back(mk_result(1'b1, sym[7:0],
                                                                        sym[15:8],
                                                                        STAT_RUNNING, len));
                                                walk = int'(root_idx);
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        if (ended) begin
                            busy = 1'b0;
                        end else begin
                            if (err != STAT_RUNNING)
                                busy = 1'b0;
                            res.push_back(mk_result(1'b0, 8'h00, 8'h00, err, len));
                        end
                    end
                end
                CMD_END: begin
                    if (busy) begin
                        busy = 1'b0;
                        res.push_back(mk_result(1'b0, 8'h00, 8'h00,
                                                (walk == root_idx) ? STAT_NO_TERM
                                                                   : STAT_TRUNCATED, len));
                    end
                end
                default: ;
            endcase
            if (res.size() > 0) begin
                r = res.pop_back();
                r.last_of_run = 1'b1;
                res.push_back(r);
            end
            if (commit) begin
                walk_idx = 12'(walk);
                out_len  = 16'(len);
                active   = busy;
                for (int i = 0; i < res.size(); i++)
                    decode_q.push_back(res[i]);
                if (it.command == CMD_WRITE_NODE || res.size() > 0)
                    live_beats++;
            end
            return reads_ok;
        endfunction

        function void note_beat(in_item_t it);
            void'(predict_decode(it, 1'b1));
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (decode_q.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = decode_q.pop_front();
            compare_field("has_symbol", want.has_symbol, got.has_symbol);
            compare_field("symbol_low", want.symbol_low, got.symbol_low);
            compare_field("symbol_high", want.symbol_high, got.symbol_high);
            compare_field("status", want.status, got.status);
            compare_field("decoded_length", want.decoded_length, got.decoded_length);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return decode_q.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives the Huffman node-table decoder with node loads, messages and end
// commands: a directed set of trees and errors first, then random trees and
// random messages over a range of register settings. Result beats are
// checked field by field against the scoreboard's prediction.
// ---------------------------------------------------------------------------
module testbench;
    import hufd_pkg::*;
    import hufd_scoreboard_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 380;
    localparam int QUIET        = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_NODE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    hufd_scoreboard sb;
    int             burst_left  = 0;
    int             rx_mode     = 0;
    int             rx_left     = 0;
    int unsigned    cycle_count = 0;
    int             tree_base   = 0;
    int             tree_leaves = 2;
    int             phase_no;
    int             directed_beats;

    huffman_table_bit_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: stretches of always-ready, random, light and heavy stalling
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            sb.check_result(m_data);
    end

    function automatic in_item_t beat_of(command_t c);
        in_item_t it;
        it.command    = c;
        it.node_index = 12'($urandom_range(0, 4095));
        it.node_word  = $urandom;
        it.data_byte  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // a beat that would read an unwritten table entry goes out as an end instead
    task automatic send(in_item_t it);
        if (!sb.predict_decode(it, 1'b0))
            it.command = CMD_END;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_beat(it);
    endtask

    task automatic send_write(int idx, logic [31:0] word);
        in_item_t it;
        it            = beat_of(CMD_WRITE_NODE);
        it.node_index = 12'(idx);
        it.node_word  = word;
        send(it);
    endtask

    task automatic send_start();
        send(beat_of(CMD_START));
    endtask

    task automatic send_data(logic [7:0] dbyte);
        in_item_t it;
        it           = beat_of(CMD_DATA);
        it.data_byte = dbyte;
        send(it);
    endtask

    task automatic send_end();
        send(beat_of(CMD_END));
    endtask

    task automatic write_reg(cfg_reg_t a, logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        sb.set_reg(a, v);
    endtask

    // registers change only with nothing outstanding and the block quiet
    task automatic set_regs(int nc, int root, int cap);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (QUIET) @(posedge aclk);
        write_reg(CFG_NODE_COUNT, 16'(nc));
        write_reg(CFG_ROOT_INDEX, 16'(root));
        write_reg(CFG_OUT_CAPACITY, 16'(cap));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_symbol();
        int k;
        k = $urandom_range(0, 29);
        if (k < 4)
            return 16'h0000;
        else if (k < 8)
            return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
        else if (k == 8)
            return {8'($urandom_range(1, 255)), 8'h00};
        else
            return {8'h00, 8'($urandom_range(1, 255))};
    endfunction

    // random full binary tree, root at root, other nodes from base upward
    task automatic build_tree(int root, int base, int leaves);
        int          open_q [$];
        int          nxt, inner_left, pick, x;
        logic [15:0] c0, c1;
        open_q.push_back(root);
        nxt        = base;
        inner_left = leaves - 1;
        while (open_q.size() > 0) begin
            pick = $urandom_range(0, open_q.size() - 1);
            x    = open_q[pick];
            open_q.delete(pick);
            if (inner_left > 0 && (x == root || open_q.size() == 0 ||
                                   $urandom_range(0, 1) == 1)) begin
                inner_left--;
                c0 = 16'(nxt);
                c1 = 16'(nxt + 1);
                send_write(x, {c1, c0});
                open_q.push_back(nxt);
                open_q.push_back(nxt + 1);
                nxt += 2;
            end else begin
                send_write(x, {LEAF_TAG, pick_symbol()});
            end
        end
    endtask

    task automatic run_message();
        if ($urandom_range(0, 7) == 0)
            send_data(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0)
            send_start();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) == 1)
                    send_write($urandom_range(0, 4095), $urandom);
                else
                    send_write(tree_base + $urandom_range(0, 2 * tree_leaves - 3),
                               {LEAF_TAG, pick_symbol()});
            end
            send_data(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 1)
            send_end();
    endtask

    task automatic run_phase(int p);
        int leaves, root, base, need_n, nc, cap;
        leaves = $urandom_range(2, 10);
        case (p % 4)
            0: root = 4095;
            1: root = 0;
            default: root = $urandom_range(0, 4095);
        endcase
        base   = (root + 2 * leaves < TABLE_ENTRIES) ? root + 1 : 0;
        need_n = (base + 2 * leaves - 2 > root + 1) ? base + 2 * leaves - 2 : root + 1;
        if (p % 4 == 0)
            nc = TABLE_ENTRIES;
        else if ($urandom_range(0, 5) == 0)
            nc = $urandom_range(1, need_n);
        else
            nc = $urandom_range(need_n, TABLE_ENTRIES);
        if (p % 4 == 1)
            cap = $urandom_range(0, 6);
        else if ($urandom_range(0, 3) == 0)
            cap = 65535;
        else
            cap = $urandom_range(7, 65535);
        set_regs(nc, root, cap);
        tree_base   = base;
        tree_leaves = leaves;
        build_tree(root, base, leaves);
        repeat ($urandom_range(3, 6)) run_message();
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // codes lsb first: 0 -> 'A', 10 -> ff ff, 110 -> end, 111 -> bad symbol
        set_regs(7, 0, 65535);
        send_write(0, 32'h0002_0001);
        send_write(1, 32'hFFFF_0041);
        send_write(2, 32'h0004_0003);
        send_write(3, 32'hFFFF_FFFF);
        send_write(4, 32'h0006_0005);
        send_write(5, 32'hFFFF_0000);
        send_write(6, 32'hFFFF_0100);
        send_start();
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h12);
        send_end();
        send_start();
        send_start();
        send_data(8'h06);
        send_start();
        send_data(8'h01);
        send_end();
        send_start();
        send_data(8'h80);
        send_end();
        // root turned into a leaf under a running message
        send_start();
        send_write(0, 32'hFFFF_0041);
        send_data(8'h00);
        send_write(0, 32'h0002_0001);
        set_regs(7, 0, 0);
        send_start();
        send_data(8'h00);
        set_regs(7, 0, 1);
        send_start();
        send_data(8'h01);
        set_regs(1, 0, 65535);
        send_start();
        send_data(8'h00);
        set_regs(1, 1, 65535);
        send_start();
        set_regs(7, 1, 65535);
        send_start();

        directed_beats = sb.live_beats;
        phase_no       = 0;
        while (sb.live_beats - directed_beats < RANDOM_BEATS) begin
            run_phase(phase_no);
            phase_no++;
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (QUIET) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
